FILE: rtl/core/stxt_pkg.sv
// Shared types, request codes and font table for the scrolling text column generator.
package stxt_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;

    // Character ranges for glyph selection
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [5:0] DIGIT_GLYPH_BASE = 6'd26;

    localparam int GLYPH_COUNT    = 36;
    localparam int GLYPH_MAX_COLS = 5;

    // Column value used for an out-of-range glyph lookup: blank, last column
    localparam logic [7:0] FONT_COL_END = 8'h01;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [4:0] char_slot;
    } t_in_word;

    typedef struct packed {
        logic [6:0] column_rows;
        logic [7:0] pixel_colour;
        logic       still_scrolling;
    } t_out_word;

    // Font columns, A-Z then 0-9; bit 0 marks the last column, bits 7:1 are rows
    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_MAX_COLS] = '{
        '{8'd126, 8'd144, 8'd144, 8'd127, 8'd0},
        '{8'd254, 8'd146, 8'd146, 8'd109, 8'd0},
        '{8'd124, 8'd130, 8'd130, 8'd69,  8'd0},
        '{8'd254, 8'd130, 8'd130, 8'd125, 8'd0},
        '{8'd254, 8'd146, 8'd146, 8'd131, 8'd0},
        '{8'd254, 8'd144, 8'd144, 8'd129, 8'd0},
        '{8'd124, 8'd130, 8'd146, 8'd93,  8'd0},
        '{8'd254, 8'd16,  8'd16,  8'd255, 8'd0},
        '{8'd130, 8'd254, 8'd131, 8'd0,   8'd0},
        '{8'd4,   8'd2,   8'd2,   8'd253, 8'd0},
        '{8'd254, 8'd16,  8'd40,  8'd199, 8'd0},
        '{8'd254, 8'd2,   8'd2,   8'd3,   8'd0},
        '{8'd254, 8'd64,  8'd48,  8'd64,  8'd255},
        '{8'd254, 8'd32,  8'd16,  8'd255, 8'd0},
        '{8'd124, 8'd130, 8'd130, 8'd125, 8'd0},
        '{8'd254, 8'd144, 8'd144, 8'd97,  8'd0},
        '{8'd124, 8'd130, 8'd138, 8'd124, 8'd3},
        '{8'd254, 8'd144, 8'd152, 8'd103, 8'd0},
        '{8'd100, 8'd146, 8'd146, 8'd77,  8'd0},
        '{8'd128, 8'd128, 8'd254, 8'd128, 8'd129},
        '{8'd252, 8'd2,   8'd2,   8'd253, 8'd0},
        '{8'd248, 8'd4,   8'd2,   8'd4,   8'd249},
        '{8'd252, 8'd2,   8'd28,  8'd2,   8'd253},
        '{8'd198, 8'd40,  8'd16,  8'd40,  8'd199},
        '{8'd224, 8'd16,  8'd14,  8'd16,  8'd225},
        '{8'd134, 8'd138, 8'd146, 8'd162, 8'd195},
        '{8'd124, 8'd146, 8'd162, 8'd125, 8'd0},
        '{8'd66,  8'd254, 8'd3,   8'd0,   8'd0},
        '{8'd70,  8'd138, 8'd146, 8'd99,  8'd0},
        '{8'd68,  8'd146, 8'd146, 8'd109, 8'd0},
        '{8'd24,  8'd40,  8'd72,  8'd255, 8'd0},
        '{8'd228, 8'd162, 8'd162, 8'd157, 8'd0},
        '{8'd124, 8'd146, 8'd146, 8'd77,  8'd0},
        '{8'd128, 8'd158, 8'd160, 8'd193, 8'd0},
        '{8'd108, 8'd146, 8'd146, 8'd109, 8'd0},
        '{8'd100, 8'd146, 8'd146, 8'd125, 8'd0}
    };

    // Look up one font column; out-of-range lookups end the glyph blank
    function automatic logic [7:0] font_col(input logic [5:0] sel, input logic [2:0] col);
        logic [7:0] result;
        if ((32'(sel) < 32'(GLYPH_COUNT)) && (32'(col) < 32'(GLYPH_MAX_COLS))) begin
            result = FONT_ROM[sel][col];
        end else begin
            result = FONT_COL_END;
        end
        return result;
    endfunction

endpackage

FILE: rtl/core/stxt_msg_store.sv
// Message store: one write port, one registered read port with write-to-read bypass.
module stxt_msg_store #(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [7:0]                 i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [7:0]                 o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; forward a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/stxt_ctrl.sv
// Execute stage: cursor and glyph state, font lookup, result register and store access.
module stxt_ctrl #(
    parameter int MSG_LEN    = 32,
    parameter int TAIL_TICKS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [7:0]                  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  stxt_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output stxt_pkg::t_out_word         o_out_word,
    output logic                        o_wr_en,
    output logic [$clog2(MSG_LEN)-1:0]  o_wr_addr,
    output logic [7:0]                  o_wr_data,
    output logic                        o_rd_en,
    output logic [$clog2(MSG_LEN)-1:0]  o_rd_addr,
    input  logic [7:0]                  i_rd_data
);

    localparam int AW = $clog2(MSG_LEN);
    localparam int PW = $clog2(MSG_LEN + 1);
    localparam int TW = $clog2(TAIL_TICKS + 1);
    localparam logic [PW-1:0] POS_END  = PW'(MSG_LEN);
    localparam logic [TW-1:0] TAIL_LOAD = TW'(TAIL_TICKS);

    // Item waiting for execution; store data for it arrives in the cycle after accept
    logic                r_s1_valid;
    stxt_pkg::t_in_word  r_s1_word;

    logic                r_out_valid;
    stxt_pkg::t_out_word r_out_word;
    logic [7:0]          r_text_colour;

    logic                r_pending, n_pending;
    logic                r_reading, n_reading;
    logic [PW-1:0]       r_read_pos, n_read_pos;
    logic                r_glyph_act, n_glyph_act;
    logic [5:0]          r_glyph_sel, n_glyph_sel;
    logic [2:0]          r_glyph_col, n_glyph_col;
    logic [TW-1:0]       r_tail, n_tail;

    logic                out_free;
    logic                fire;
    logic                accept;
    logic                is_tick;
    logic [7:0]          col;
    logic                finished;
    logic [TW-1:0]       tail_mid;
    logic [7:0]          ch;

    assign is_tick  = (r_s1_word.req_type == stxt_pkg::REQ_TICK);
    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = r_s1_valid && (!is_tick || out_free);
    assign o_in_stall = r_s1_valid && !fire;
    assign accept   = i_in_valid && !o_in_stall;
    assign ch       = i_rd_data;

    // Execute the held word against the current state
    always_comb begin
        n_pending   = r_pending;
        n_reading   = r_reading;
        n_read_pos  = r_read_pos;
        n_glyph_act = r_glyph_act;
        n_glyph_sel = r_glyph_sel;
        n_glyph_col = r_glyph_col;
        n_tail      = r_tail;
        tail_mid    = r_tail;
        col         = 8'd0;
        finished    = 1'b0;
        o_wr_en     = 1'b0;
        if (fire) begin
            unique case (r_s1_word.req_type)
                stxt_pkg::REQ_WRITE: begin
                    o_wr_en = (32'(r_s1_word.char_slot) < 32'(MSG_LEN));
                end
                stxt_pkg::REQ_COMMIT: begin
                    n_glyph_act = 1'b0;
                    n_glyph_col = 3'd0;
                    n_reading   = 1'b0;
                    n_read_pos  = '0;
                    n_pending   = 1'b1;
                end
                stxt_pkg::REQ_TICK: begin
                    priority if (r_glyph_act) begin
                        col = stxt_pkg::font_col(r_glyph_sel, r_glyph_col);
                        if (col[0]) begin
                            n_glyph_act = 1'b0;
                            n_glyph_col = 3'd0;
                        end else begin
                            n_glyph_col = r_glyph_col + 3'd1;
                        end
                    end else if (r_reading) begin
                        if (r_read_pos >= POS_END) begin
                            n_reading = 1'b0;
                            tail_mid  = TAIL_LOAD;
                        end else begin
                            n_read_pos = r_read_pos + PW'(1);
                            priority if (ch == 8'd0) begin
                                n_reading = 1'b0;
                                tail_mid  = TAIL_LOAD;
                            end else if (ch >= stxt_pkg::CHAR_LOWER_A &&
                                         ch <= stxt_pkg::CHAR_LOWER_Z) begin
                                n_glyph_sel = 6'(ch - stxt_pkg::CHAR_LOWER_A);
                                n_glyph_act = 1'b1;
                                n_glyph_col = 3'd0;
                            end else if (ch >= stxt_pkg::CHAR_UPPER_A &&
                                         ch <= stxt_pkg::CHAR_UPPER_Z) begin
                                n_glyph_sel = 6'(ch - stxt_pkg::CHAR_UPPER_A);
                                n_glyph_act = 1'b1;
                                n_glyph_col = 3'd0;
                            end else if (ch >= stxt_pkg::CHAR_DIGIT_0 &&
                                         ch <= stxt_pkg::CHAR_DIGIT_9) begin
                                n_glyph_sel = stxt_pkg::DIGIT_GLYPH_BASE +
                                              6'(ch - stxt_pkg::CHAR_DIGIT_0);
                                n_glyph_act = 1'b1;
                                n_glyph_col = 3'd0;
                            end else begin
                                n_glyph_sel = r_glyph_sel;
                            end
                        end
                    end else begin
                        finished   = !r_pending;
                        n_reading  = r_pending;
                        n_read_pos = '0;
                        n_pending  = 1'b0;
                    end
                    // Count down the tail after any reload
                    n_tail   = (tail_mid != '0) ? (tail_mid - TW'(1)) : '0;
                    finished = finished && (n_tail == '0);
                end
                default: begin
                    n_tail = r_tail;
                end
            endcase
        end
    end

    // Store ports: write at execute, read at accept from the post-execute cursor
    assign o_wr_addr = AW'(r_s1_word.char_slot);
    assign o_wr_data = r_s1_word.char_code;
    assign o_rd_en   = accept;
    assign o_rd_addr = n_read_pos[AW-1:0];

    // Advance the held word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_word <= i_in_word;
        end
    end

    // Hold cursor and glyph state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_reading   <= 1'b0;
            r_read_pos  <= '0;
            r_glyph_act <= 1'b0;
            r_glyph_sel <= 6'd0;
            r_glyph_col <= 3'd0;
            r_tail      <= '0;
        end else begin
            r_pending   <= n_pending;
            r_reading   <= n_reading;
            r_read_pos  <= n_read_pos;
            r_glyph_act <= n_glyph_act;
            r_glyph_sel <= n_glyph_sel;
            r_glyph_col <= n_glyph_col;
            r_tail      <= n_tail;
        end
    end

    // Colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_colour <= 8'd1;
        end else if (i_cfg_wr_en) begin
            r_text_colour <= i_cfg_wr_data;
        end
    end

    // Result register: load on a tick, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_tick) begin
            r_out_word.column_rows     <= col[7:1];
            r_out_word.pixel_colour    <= r_text_colour;
            r_out_word.still_scrolling <= !finished;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/core/scrolling_text_column_generator_top.sv
// Top level of the scrolling text column generator: control stage plus message store.
//
// Each scroll tick yields one 7-row display column in the configured colour and a
// still-scrolling flag; character writes and commits yield no result. One word is
// accepted per clock cycle unless the input stalls; it waits in a register and
// executes once the store's registered read for it has returned (the read is issued
// at acceptance from the cursor as the preceding word leaves it, and a write to the
// same entry in that cycle is forwarded); a tick's result is then registered. Input
// stalls only while a tick waits behind a result not taken. The store is not cleared
// after reset: the user must write each entry before it is read; not enforced.
module scrolling_text_column_generator_top #(
    parameter int MSG_LEN    = 32,
    parameter int TAIL_TICKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stxt_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stxt_pkg::t_out_word  o_out_word
);

    localparam int AW = $clog2(MSG_LEN);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    stxt_ctrl #(
        .MSG_LEN    (MSG_LEN),
        .TAIL_TICKS (TAIL_TICKS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    stxt_msg_store #(
        .DEPTH (MSG_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

FILE: bench/scrolling_text_column_generator_top_tb.sv
// Self-checking testbench for the scrolling text column generator top level.
`timescale 1ns / 1ps

module scrolling_text_column_generator_top_tb;

    localparam int          MSG_DEPTH    = 32;
    localparam int          TAIL_LEN     = 16;
    localparam int          GLYPHS       = 36;
    localparam int          GLYPH_WIDTH  = 5;
    localparam int          RANDOM_WORDS = 550;
    localparam int          STEADY_WORDS = 150;
    localparam int          LONG_HOLD    = 60;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          PRINT_LIMIT  = 40;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_SPACE     = " ";
    localparam logic [7:0]  CH_LOWER_A   = "a";
    localparam logic [7:0]  CH_LOWER_Z   = "z";
    localparam logic [7:0]  CH_UPPER_A   = "A";
    localparam logic [7:0]  CH_UPPER_Z   = "Z";
    localparam logic [7:0]  CH_DIGIT_0   = "0";
    localparam logic [7:0]  CH_DIGIT_9   = "9";
    localparam logic [5:0]  DIGIT_BASE   = 6'd26;
    localparam logic [7:0]  COL_END      = 8'h01;
    localparam logic [7:0]  RESET_COLOUR = 8'h01;

    // Font columns, A-Z then 0-9; bit 0 ends the glyph, bits 7:1 are the rows
    localparam logic [7:0] GLYPH_FONT [GLYPHS][GLYPH_WIDTH] = '{
        '{8'd126, 8'd144, 8'd144, 8'd127, 8'd0},   '{8'd254, 8'd146, 8'd146, 8'd109, 8'd0},
        '{8'd124, 8'd130, 8'd130, 8'd69,  8'd0},   '{8'd254, 8'd130, 8'd130, 8'd125, 8'd0},
        '{8'd254, 8'd146, 8'd146, 8'd131, 8'd0},   '{8'd254, 8'd144, 8'd144, 8'd129, 8'd0},
        '{8'd124, 8'd130, 8'd146, 8'd93,  8'd0},   '{8'd254, 8'd16,  8'd16,  8'd255, 8'd0},
        '{8'd130, 8'd254, 8'd131, 8'd0,   8'd0},   '{8'd4,   8'd2,   8'd2,   8'd253, 8'd0},
        '{8'd254, 8'd16,  8'd40,  8'd199, 8'd0},   '{8'd254, 8'd2,   8'd2,   8'd3,   8'd0},
        '{8'd254, 8'd64,  8'd48,  8'd64,  8'd255}, '{8'd254, 8'd32,  8'd16,  8'd255, 8'd0},
        '{8'd124, 8'd130, 8'd130, 8'd125, 8'd0},   '{8'd254, 8'd144, 8'd144, 8'd97,  8'd0},
        '{8'd124, 8'd130, 8'd138, 8'd124, 8'd3},   '{8'd254, 8'd144, 8'd152, 8'd103, 8'd0},
        '{8'd100, 8'd146, 8'd146, 8'd77,  8'd0},   '{8'd128, 8'd128, 8'd254, 8'd128, 8'd129},
        '{8'd252, 8'd2,   8'd2,   8'd253, 8'd0},   '{8'd248, 8'd4,   8'd2,   8'd4,   8'd249},
        '{8'd252, 8'd2,   8'd28,  8'd2,   8'd253}, '{8'd198, 8'd40,  8'd16,  8'd40,  8'd199},
        '{8'd224, 8'd16,  8'd14,  8'd16,  8'd225}, '{8'd134, 8'd138, 8'd146, 8'd162, 8'd195},
        '{8'd124, 8'd146, 8'd162, 8'd125, 8'd0},   '{8'd66,  8'd254, 8'd3,   8'd0,   8'd0},
        '{8'd70,  8'd138, 8'd146, 8'd99,  8'd0},   '{8'd68,  8'd146, 8'd146, 8'd109, 8'd0},
        '{8'd24,  8'd40,  8'd72,  8'd255, 8'd0},   '{8'd228, 8'd162, 8'd162, 8'd157, 8'd0},
        '{8'd124, 8'd146, 8'd146, 8'd77,  8'd0},   '{8'd128, 8'd158, 8'd160, 8'd193, 8'd0},
        '{8'd108, 8'd146, 8'd146, 8'd109, 8'd0},   '{8'd100, 8'd146, 8'd146, 8'd125, 8'd0}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [7:0]          i_cfg_wr_data = 8'h00;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    stxt_pkg::t_in_word  i_in_word     = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    stxt_pkg::t_out_word o_out_word;

    // Marquee state as the block should hold it
    logic [7:0] store_chars [MSG_DEPTH];
    bit         store_valid [MSG_DEPTH];
    bit         commit_waiting = 1'b0;
    bit         msg_running    = 1'b0;
    logic [5:0] msg_cursor     = '0;
    bit         glyph_live     = 1'b0;
    logic [5:0] glyph_id       = '0;
    logic [2:0] glyph_step     = '0;
    logic [4:0] tail_left      = '0;
    logic [7:0] colour_now     = RESET_COLOUR;

    stxt_pkg::t_out_word due_columns [$];
    stxt_pkg::t_out_word col_want;
    int unsigned words_sent    = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    bit          tx_idle_on    = 1'b0;
    bit          rx_idle_on    = 1'b0;
    bit          hold_request  = 1'b0;

    scrolling_text_column_generator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        end
        mismatches++;
    endtask

    function automatic stxt_pkg::t_in_word make_word(input logic [1:0] req,
                                                     input logic [7:0] ch,
                                                     input logic [4:0] slot);
        stxt_pkg::t_in_word w;
        w.req_type  = req;
        w.char_code = ch;
        w.char_slot = slot;
        return w;
    endfunction

    // Pick a character: letters of both cases, digits, or any nonzero byte
    function automatic logic [7:0] rand_char();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0: ch = CH_UPPER_A + 8'($urandom_range(0, 25));
            1: ch = CH_LOWER_A + 8'($urandom_range(0, 25));
            2: ch = CH_DIGIT_0 + 8'($urandom_range(0, 9));
            default: ch = 8'($urandom_range(1, 255));
        endcase
        return ch;
    endfunction

    function automatic bit display_idle();
        return !glyph_live && !msg_running && !commit_waiting && tail_left == 0;
    endfunction

    // Apply one accepted word to the marquee state; a tick queues its column
    function automatic void advance_marquee(input stxt_pkg::t_in_word w);
        logic [7:0]          font_bits;
        logic [7:0]          ch;
        bit                  at_rest;
        stxt_pkg::t_out_word col;
        font_bits = 8'h00;
        at_rest   = 1'b0;
        case (w.req_type)
            stxt_pkg::REQ_WRITE: begin
                store_chars[w.char_slot] = w.char_code;
                store_valid[w.char_slot] = 1'b1;
            end
            stxt_pkg::REQ_COMMIT: begin
                glyph_live     = 1'b0;
                glyph_step     = '0;
                msg_running    = 1'b0;
                msg_cursor     = '0;
                commit_waiting = 1'b1;
            end
            stxt_pkg::REQ_TICK: begin
                if (glyph_live) begin
                    if (glyph_id < GLYPHS && glyph_step < GLYPH_WIDTH) begin
                        font_bits = GLYPH_FONT[glyph_id][glyph_step];
                    end else begin
                        font_bits = COL_END;
                    end
                    if (font_bits[0]) begin
                        glyph_live = 1'b0;
                        glyph_step = '0;
                    end else begin
                        glyph_step = glyph_step + 3'd1;
                    end
                end else if (msg_running) begin
                    ch = CH_NUL;
                    if (msg_cursor < MSG_DEPTH) begin
                        ch = store_chars[msg_cursor[4:0]];
                        msg_cursor = msg_cursor + 6'd1;
                    end
                    if (ch == CH_NUL) begin
                        msg_running = 1'b0;
                        tail_left   = 5'(TAIL_LEN);
                    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
                        glyph_id   = 6'(ch - CH_LOWER_A);
                        glyph_live = 1'b1;
                        glyph_step = '0;
                    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
                        glyph_id   = 6'(ch - CH_UPPER_A);
                        glyph_live = 1'b1;
                        glyph_step = '0;
                    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
                        glyph_id   = DIGIT_BASE + 6'(ch - CH_DIGIT_0);
                        glyph_live = 1'b1;
                        glyph_step = '0;
                    end
                end else begin
                    at_rest        = !commit_waiting;
                    msg_running    = commit_waiting;
                    msg_cursor     = '0;
                    commit_waiting = 1'b0;
                end
                if (tail_left != 0) tail_left = tail_left - 5'd1;
                col.column_rows     = font_bits[7:1];
                col.pixel_colour    = colour_now;
                col.still_scrolling = !(at_rest && tail_left == 0);
                due_columns.push_back(col);
            end
            default: ;
        endcase
    endfunction

    // Offer one word, sometimes after a random gap, and hold it until accepted
    task automatic push_word(input stxt_pkg::t_in_word w);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_marquee(w);
        if (w.req_type != REQ_UNUSED) words_sent++;
    endtask

    // Fill the entry a tick is about to read if it was never written
    task automatic send_word(input stxt_pkg::t_in_word w);
        if (w.req_type == stxt_pkg::REQ_TICK && !glyph_live && msg_running
            && msg_cursor < MSG_DEPTH && !store_valid[msg_cursor[4:0]]) begin
            push_word(make_word(stxt_pkg::REQ_WRITE, rand_char(), msg_cursor[4:0]));
        end
        push_word(w);
    endtask

    task automatic send_tick();
        send_word(make_word(stxt_pkg::REQ_TICK, 8'($urandom), 5'($urandom)));
    endtask

    // Tick until the display is blank, then once more to see the flag drop
    task automatic scroll_out();
        while (!display_idle()) send_tick();
        send_tick();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_columns.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_colour(input logic [7:0] shade);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= shade;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        colour_now = shade;
    endtask

    // Write a message of random length and content, commit, and scroll it
    task automatic play_message();
        int len;
        int i;
        if ($urandom_range(0, 9) == 0) len = MSG_DEPTH;
        else len = $urandom_range(0, 10);
        for (i = 0; i < len; i++)
            send_word(make_word(stxt_pkg::REQ_WRITE, rand_char(), 5'(i)));
        if (len < MSG_DEPTH) send_word(make_word(stxt_pkg::REQ_WRITE, CH_NUL, 5'(len)));
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'($urandom), 5'($urandom)));
        if ($urandom_range(0, 3) == 0) begin
            // leave it mid-display, or rewrite some entry and then scroll it out
            repeat ($urandom_range(1, 25)) send_tick();
            if ($urandom_range(0, 1) == 0) begin
                send_word(make_word(stxt_pkg::REQ_WRITE, 8'($urandom), 5'($urandom)));
                scroll_out();
            end
        end else begin
            scroll_out();
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) begin
            send_word(make_word(2'($urandom_range(0, 3)), 8'($urandom), 5'($urandom)));
        end
    endtask

    task automatic test_after_reset();
        // nothing pending: blank columns in the reset colour, flag low
        repeat (3) send_tick();
        send_word(make_word(REQ_UNUSED, 8'hFF, 5'd31));
        send_tick();
    endtask

    task automatic test_directed_message();
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_LOWER_A, 5'd0));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_UPPER_Z, 5'd1));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_DIGIT_0, 5'd2));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_DIGIT_9, 5'd3));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_SPACE, 5'd4));
        send_word(make_word(stxt_pkg::REQ_WRITE, 8'hFF, 5'd5));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_NUL, 5'd6));
        send_word(make_word(stxt_pkg::REQ_WRITE, 8'hFF, 5'd31));
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
        repeat (5) send_tick();
        // restart in the middle of a glyph
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'hFF, 5'd31));
        repeat (7) send_tick();
        // rewrite the entry read next and the one two further on while on display
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_UPPER_A, 5'd2));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_LOWER_Z, 5'd4));
        scroll_out();
        // commit again while the tail runs; the countdown carries on
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_DIGIT_9, 5'd0));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_NUL, 5'd1));
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
        while (msg_running || glyph_live || commit_waiting) send_tick();
        repeat (3) send_tick();
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
        scroll_out();
    endtask

    task automatic test_store_end();
        int i;
        // no terminator anywhere: reading runs off the end of the store
        for (i = 0; i < MSG_DEPTH; i++)
            send_word(make_word(stxt_pkg::REQ_WRITE, rand_char(), 5'(i)));
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
        scroll_out();
    endtask

    task automatic test_colour_settings();
        int k;
        for (k = 0; k < 4; k++) begin
            case (k)
                0: set_colour(8'h00);
                1: set_colour(8'hFF);
                2: set_colour(8'h80);
                default: set_colour(8'($urandom));
            endcase
            send_word(make_word(stxt_pkg::REQ_WRITE, rand_char(), 5'd0));
            send_word(make_word(stxt_pkg::REQ_WRITE, CH_NUL, 5'd1));
            send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
            scroll_out();
        end
        set_colour(RESET_COLOUR);
    endtask

    task automatic test_output_backpressure();
        int i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (i = 0; i < 6; i++)
            send_word(make_word(stxt_pkg::REQ_WRITE, rand_char(), 5'(i)));
        send_word(make_word(stxt_pkg::REQ_WRITE, CH_NUL, 5'd6));
        send_word(make_word(stxt_pkg::REQ_COMMIT, 8'h00, 5'd0));
        // keep offering ticks while the receiver holds off
        hold_request = 1'b1;
        repeat (40) send_tick();
        scroll_out();
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        goal = words_sent + RANDOM_WORDS;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (words_sent < goal) begin
            case ($urandom_range(0, 19))
                0, 1, 2: send_noise($urandom_range(1, 6));
                3: set_colour(8'($urandom));
                4: begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                end
                default: play_message();
            endcase
        end
    endtask

    task automatic test_steady_stream();
        int unsigned goal;
        goal = words_sent + STEADY_WORDS;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (words_sent < goal) play_message();
    endtask

    // Receiver stalls: random bursts, or one long hold when asked
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            i_out_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            hold_request = 1'b0;
            i_out_stall <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted column word with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_columns.size() == 0) begin
                report_mismatch("column word with no tick waiting", o_out_word, 0);
            end else begin
                col_want = due_columns.pop_front();
                if (o_out_word.column_rows !== col_want.column_rows)
                    report_mismatch("column_rows", o_out_word.column_rows,
                                    col_want.column_rows);
                if (o_out_word.pixel_colour !== col_want.pixel_colour)
                    report_mismatch("pixel_colour", o_out_word.pixel_colour,
                                    col_want.pixel_colour);
                if (o_out_word.still_scrolling !== col_want.still_scrolling)
                    report_mismatch("still_scrolling", o_out_word.still_scrolling,
                                    col_want.still_scrolling);
            end
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned drain_wait;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_directed_message();
        test_store_end();
        test_colour_settings();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        // drain the last columns, then watch for strays
        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (due_columns.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (due_columns.size() != 0)
            report_mismatch("columns never delivered", due_columns.size(), 0);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
